>>> hw/rtl/bes_pkg.sv
// Shared constants and helpers for the ball Euler step block.
package bes_pkg;

  // Field size defaults, in whole pixels
  localparam int unsigned FIELD_WIDTH_DEF  = 1000;
  localparam int unsigned FIELD_HEIGHT_DEF = 700;

  // Fixed-point widths
  localparam int unsigned POS_W = 18;  // Q10.8 unsigned
  localparam int unsigned VEL_W = 23;  // Q14.8 signed
  localparam int unsigned WP_W  = 25;  // working position, signed

  // Shared multiplier operand and product widths
  localparam int unsigned MUL_A_W = 25;  // signed
  localparam int unsigned MUL_B_W = 17;  // unsigned
  localparam int unsigned MUL_P_W = 42;  // signed

  // Configuration register indexes
  localparam logic [2:0] REG_GRAVITY    = 3'd0;
  localparam logic [2:0] REG_DRAG       = 3'd1;
  localparam logic [2:0] REG_ELASTICITY = 3'd2;
  localparam logic [2:0] REG_RADIUS     = 3'd3;
  localparam logic [2:0] REG_PLAT_LEFT  = 3'd4;
  localparam logic [2:0] REG_PLAT_TOP   = 3'd5;
  localparam logic [2:0] REG_PLAT_W     = 3'd6;
  localparam logic [2:0] REG_PLAT_H     = 3'd7;

  // Configuration reset values
  localparam logic [21:0] GRAVITY_RST    = 22'd250880;
  localparam logic [15:0] DRAG_RST       = 16'd410;
  localparam logic [16:0] ELASTICITY_RST = 17'd52429;
  localparam logic [15:0] RADIUS_RST     = 16'd5120;
  localparam logic [17:0] PLAT_LEFT_RST  = 18'd51200;
  localparam logic [17:0] PLAT_TOP_RST   = 18'd153600;
  localparam logic [17:0] PLAT_W_RST     = 18'd153600;
  localparam logic [17:0] PLAT_H_RST     = 18'd5120;

  // Elasticity of one in Q1.16
  localparam logic [16:0] ELAS_ONE = 17'd65536;

  // Wall hit codes
  localparam logic [1:0] HIT_NONE = 2'd0;
  localparam logic [1:0] HIT_LOW  = 2'd1;  // left or top wall
  localparam logic [1:0] HIT_HIGH = 2'd2;  // right or bottom wall

  // Platform side codes
  localparam logic [2:0] SIDE_NONE   = 3'd0;
  localparam logic [2:0] SIDE_TOP    = 3'd1;
  localparam logic [2:0] SIDE_BOTTOM = 3'd2;
  localparam logic [2:0] SIDE_LEFT   = 3'd3;
  localparam logic [2:0] SIDE_RIGHT  = 3'd4;

  // Velocity and position limits
  localparam logic signed [31:0] VEL_MAX = 32'sd4194303;
  localparam logic signed [31:0] VEL_MIN = -32'sd4194304;
  localparam logic signed [24:0] POS_MAX = 25'sd262143;

  // Saturate a wide velocity to Q14.8
  function automatic logic signed [22:0] sat_vel(input logic signed [31:0] v);
    logic signed [22:0] r;
    if (v > VEL_MAX) begin
      r = 23'sh3fffff;
    end else if (v < VEL_MIN) begin
      r = -23'sh400000;
    end else begin
      r = v[22:0];
    end
    return r;
  endfunction

  // Clamp a working position to the Q10.8 range
  function automatic logic [17:0] clamp_pos(input logic signed [24:0] p);
    logic [17:0] r;
    if (p < 25'sd0) begin
      r = 18'd0;
    end else if (p > POS_MAX) begin
      r = 18'h3ffff;
    end else begin
      r = p[17:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/bes_mul.sv
// Shared signed-by-unsigned multiplier with a registered product.
module bes_mul import bes_pkg::*; (
  input  logic                              clk_i,
  input  logic signed [MUL_A_W-1:0]         a_i,
  input  logic        [MUL_B_W-1:0]         b_i,
  output logic signed [MUL_P_W-1:0]         prod_o
);

  logic signed [MUL_A_W+MUL_B_W:0] full;
  logic signed [MUL_P_W-1:0]       prod_q;

  // Multiply; the product always fits the narrower register
  assign full = a_i * $signed({1'b0, b_i});

  // Register the product
  always_ff @(posedge clk_i) begin
    prod_q <= full[MUL_P_W-1:0];
  end

  assign prod_o = prod_q;

endmodule

>>> hw/rtl/ball_euler_step_with_bounce.sv
// Top level: one ball stepped by semi-implicit Euler with wall and platform bounce.
//
// The block keeps the position and velocity of one ball. A request with
// tuser set loads position and velocity; one with tuser clear advances by
// step_dt under gravity and linear drag, then resolves the field walls and
// one platform. Every request yields one result with the new state and the
// hit sides. All multiplications run through one 25x17 multiplier with a
// registered product, stepped by a sequencer: the block takes no new request
// until the result of the current one has entered the output register.
// The result sits in an output register, so the next request is taken while
// it waits; a later result waits in the sequencer until that one is taken.
// Configuration is written through the plain write port; the user must write
// it only while idle, as the block itself does not enforce this.
module ball_euler_step_with_bounce import bes_pkg::*; #(
  parameter int unsigned FIELD_WIDTH  = FIELD_WIDTH_DEF,
  parameter int unsigned FIELD_HEIGHT = FIELD_HEIGHT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write port
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [21:0]  cfg_data_i,
  // Request channel
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // step_dt[15:0], load_pos_x[33:16], load_pos_y[51:34],
  // load_vel_x[74:52], load_vel_y[97:75], zero pad
  input  logic [103:0] s_axis_tdata,
  // opcode[0]
  input  logic [0:0]   s_axis_tuser,
  // Result channel
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x[17:0], pos_y[35:18], vel_x[58:36], vel_y[81:59],
  // wall_hit_x[83:82], wall_hit_y[85:84], platform_side[88:86], zero pad
  output logic [95:0]  m_axis_tdata
);

  localparam logic signed [25:0] FW = 26'(FIELD_WIDTH * 256);
  localparam logic signed [25:0] FH = 26'(FIELD_HEIGHT * 256);
  localparam logic signed [57:0] H28 = 58'sd134217728;
  localparam logic signed [41:0] H16 = 42'sd32768;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DRAG, ST_ACCEL, ST_MLO, ST_MHI, ST_MADD, ST_VUPD, ST_PMUL,
    ST_PUPD, ST_WALL, ST_WREFL, ST_PLAT, ST_PREFL, ST_FIN
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [21:0] grav_q;
  logic [15:0] drag_q;
  logic [16:0] elas_q;
  logic [15:0] radius_q;
  logic [17:0] pl_q, pt_q, pw_q, ph_q;

  // Ball state and working registers
  logic [17:0]           pos_x_q, pos_y_q;
  logic signed [22:0]    vel_x_q, vel_y_q;
  logic signed [24:0]    wpx_q, wpy_q;
  logic                  axis_q;
  logic [15:0]           dt_q;
  logic signed [40:0]    accel_q;
  logic signed [57:0]    acc_q;
  logic [1:0]            hit_x_q, hit_y_q;
  logic [2:0]            side_q;
  logic                  m_valid_q;
  logic [95:0]           m_data_q;

  // Shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic        [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  bes_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Select the current axis
  logic signed [22:0] v_cur;
  logic [17:0]        p_old;
  logic signed [24:0] pw_cur;
  logic [16:0]        e_eff;

  assign v_cur  = axis_q ? vel_y_q : vel_x_q;
  assign p_old  = axis_q ? pos_y_q : pos_x_q;
  assign pw_cur = axis_q ? wpy_q : wpx_q;
  assign e_eff  = (elas_q > ELAS_ONE) ? ELAS_ONE : elas_q;

  // Acceleration: gravity on the vertical axis minus drag times velocity
  logic signed [40:0] accel_next;
  assign accel_next = (axis_q ? $signed({7'b0, grav_q, 12'b0}) : 41'sd0) - prod[40:0];

  // Velocity update: round accel*dt by 2^28, half away from zero
  logic signed [57:0] acc_rnd;
  logic signed [31:0] v_sum;
  logic signed [22:0] v_step;
  assign acc_rnd = (acc_q + (acc_q[57] ? (H28 - 58'sd1) : H28)) >>> 28;
  assign v_sum   = 32'(v_cur) + acc_rnd[31:0];
  assign v_step  = sat_vel(v_sum);

  // Position update: round v*dt by 2^16
  logic signed [41:0] prod_r16;
  logic signed [24:0] p_step;
  assign prod_r16 = (prod + (prod[41] ? (H16 - 42'sd1) : H16)) >>> 16;
  assign p_step   = $signed({7'b0, p_old}) + prod_r16[24:0];

  // Reflection: negate the rounded v*e and saturate
  logic signed [31:0] v_neg;
  logic signed [22:0] v_refl;
  assign v_neg  = -32'($signed(prod_r16[24:0]));
  assign v_refl = sat_vel(v_neg);

  // Wall test on the current axis
  logic signed [25:0] r26, pw26, lim;
  logic               wall_low, wall_high;
  logic signed [24:0] wall_p;
  logic [1:0]         wall_hit;
  assign r26       = $signed({10'b0, radius_q});
  assign pw26      = 26'(pw_cur);
  assign lim       = axis_q ? FH : FW;
  assign wall_low  = pw26 < r26;
  assign wall_high = (pw26 + r26) > lim;

  always_comb begin
    wall_p   = pw_cur;
    wall_hit = HIT_NONE;
    if (wall_low) begin
      wall_p   = r26[24:0];
      wall_hit = HIT_LOW;
    end else if (wall_high) begin
      wall_p   = 25'(lim - r26);
      wall_hit = HIT_HIGH;
    end
  end

  // Platform test on the wall-clamped position
  logic signed [20:0] sx, sy, r21, pl21, pt21, pr21, pb21;
  logic               in_x, in_y, vx_pos, vx_neg, vy_pos, vy_neg;
  logic [2:0]         side_c;
  logic signed [20:0] plat_px, plat_py;
  logic signed [22:0] plat_v;

  assign sx   = $signed({3'b0, wpx_q[17:0]});
  assign sy   = $signed({3'b0, wpy_q[17:0]});
  assign r21  = $signed({5'b0, radius_q});
  assign pl21 = $signed({3'b0, pl_q});
  assign pt21 = $signed({3'b0, pt_q});
  assign pr21 = $signed({3'b0, pl_q}) + $signed({3'b0, pw_q});
  assign pb21 = $signed({3'b0, pt_q}) + $signed({3'b0, ph_q});
  assign in_x = ((sx + r21) > pl21) && ((sx - r21) < pr21);
  assign in_y = ((sy + r21) > pt21) && ((sy - r21) < pb21);
  assign vx_neg = vel_x_q[22];
  assign vy_neg = vel_y_q[22];
  assign vx_pos = !vel_x_q[22] && (vel_x_q != 23'sd0);
  assign vy_pos = !vel_y_q[22] && (vel_y_q != 23'sd0);

  always_comb begin
    side_c  = SIDE_NONE;
    plat_px = sx;
    plat_py = sy;
    if (((sy + r21) > pt21) && (sy < pt21) && in_x && vy_pos) begin
      side_c  = SIDE_TOP;
      plat_py = pt21 - r21;
    end else if (((sy - r21) < pb21) && (sy > pb21) && in_x && vy_neg) begin
      side_c  = SIDE_BOTTOM;
      plat_py = pb21 + r21;
    end else if (((sx + r21) > pl21) && (sx < pl21) && in_y && vx_pos) begin
      side_c  = SIDE_LEFT;
      plat_px = pl21 - r21;
    end else if (((sx - r21) < pr21) && (sx > pr21) && in_y && vx_neg) begin
      side_c  = SIDE_RIGHT;
      plat_px = pr21 + r21;
    end
  end

  assign plat_v = ((side_c == SIDE_TOP) || (side_c == SIDE_BOTTOM)) ? vel_y_q : vel_x_q;

  // Route operands to the shared multiplier
  always_comb begin
    mul_a = 25'(v_cur);
    mul_b = {1'b0, dt_q};
    case (state_q)
      ST_DRAG: begin
        mul_b = {1'b0, drag_q};
      end
      ST_MLO: begin
        mul_a = $signed({5'b0, accel_q[19:0]});
      end
      ST_MHI: begin
        mul_a = 25'($signed(accel_q[40:20]));
      end
      ST_WALL: begin
        mul_b = e_eff;
      end
      ST_PLAT: begin
        mul_a = 25'(plat_v);
        mul_b = e_eff;
      end
      default: begin
        mul_a = 25'(v_cur);
      end
    endcase
  end

  // Sequencer, state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      axis_q    <= 1'b0;
      m_valid_q <= 1'b0;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      vel_x_q   <= '0;
      vel_y_q   <= '0;
      hit_x_q   <= HIT_NONE;
      hit_y_q   <= HIT_NONE;
      side_q    <= SIDE_NONE;
      grav_q    <= GRAVITY_RST;
      drag_q    <= DRAG_RST;
      elas_q    <= ELASTICITY_RST;
      radius_q  <= RADIUS_RST;
      pl_q      <= PLAT_LEFT_RST;
      pt_q      <= PLAT_TOP_RST;
      pw_q      <= PLAT_W_RST;
      ph_q      <= PLAT_H_RST;
    end else begin
      // Take configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GRAVITY:    grav_q   <= cfg_data_i;
          REG_DRAG:       drag_q   <= cfg_data_i[15:0];
          REG_ELASTICITY: elas_q   <= cfg_data_i[16:0];
          REG_RADIUS:     radius_q <= cfg_data_i[15:0];
          REG_PLAT_LEFT:  pl_q     <= cfg_data_i[17:0];
          REG_PLAT_TOP:   pt_q     <= cfg_data_i[17:0];
          REG_PLAT_W:     pw_q     <= cfg_data_i[17:0];
          REG_PLAT_H:     ph_q     <= cfg_data_i[17:0];
          default: begin
          end
        endcase
      end

      // Drop the result once taken; the final state refills it itself
      if (m_valid_q && m_axis_tready && (state_q != ST_FIN)) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            dt_q    <= s_axis_tdata[15:0];
            axis_q  <= 1'b0;
            hit_x_q <= HIT_NONE;
            hit_y_q <= HIT_NONE;
            side_q  <= SIDE_NONE;
            if (s_axis_tuser[0]) begin
              pos_x_q <= s_axis_tdata[33:16];
              pos_y_q <= s_axis_tdata[51:34];
              vel_x_q <= $signed(s_axis_tdata[74:52]);
              vel_y_q <= $signed(s_axis_tdata[97:75]);
              state_q <= ST_FIN;
            end else begin
              state_q <= ST_DRAG;
            end
          end
        end
        ST_DRAG: begin
          state_q <= ST_ACCEL;
        end
        ST_ACCEL: begin
          accel_q <= accel_next;
          state_q <= ST_MLO;
        end
        ST_MLO: begin
          state_q <= ST_MHI;
        end
        ST_MHI: begin
          acc_q   <= $signed({22'b0, prod[35:0]});
          state_q <= ST_MADD;
        end
        ST_MADD: begin
          acc_q   <= acc_q + $signed({prod[36], prod[36:0], 20'b0});
          state_q <= ST_VUPD;
        end
        ST_VUPD: begin
          if (axis_q) begin
            vel_y_q <= v_step;
          end else begin
            vel_x_q <= v_step;
          end
          state_q <= ST_PMUL;
        end
        ST_PMUL: begin
          state_q <= ST_PUPD;
        end
        ST_PUPD: begin
          if (axis_q) begin
            wpy_q   <= p_step;
            axis_q  <= 1'b0;
            state_q <= ST_WALL;
          end else begin
            wpx_q   <= p_step;
            axis_q  <= 1'b1;
            state_q <= ST_DRAG;
          end
        end
        ST_WALL: begin
          if (axis_q) begin
            wpy_q   <= $signed({7'b0, clamp_pos(wall_p)});
            hit_y_q <= wall_hit;
          end else begin
            wpx_q   <= $signed({7'b0, clamp_pos(wall_p)});
            hit_x_q <= wall_hit;
          end
          state_q <= ST_WREFL;
        end
        ST_WREFL: begin
          if (axis_q) begin
            if (hit_y_q != HIT_NONE) begin
              vel_y_q <= v_refl;
            end
            axis_q  <= 1'b0;
            state_q <= ST_PLAT;
          end else begin
            if (hit_x_q != HIT_NONE) begin
              vel_x_q <= v_refl;
            end
            axis_q  <= 1'b1;
            state_q <= ST_WALL;
          end
        end
        ST_PLAT: begin
          side_q  <= side_c;
          wpx_q   <= 25'(plat_px);
          wpy_q   <= 25'(plat_py);
          state_q <= ST_PREFL;
        end
        ST_PREFL: begin
          if ((side_q == SIDE_TOP) || (side_q == SIDE_BOTTOM)) begin
            vel_y_q <= v_refl;
          end else if ((side_q == SIDE_LEFT) || (side_q == SIDE_RIGHT)) begin
            vel_x_q <= v_refl;
          end
          pos_x_q <= clamp_pos(wpx_q);
          pos_y_q <= clamp_pos(wpy_q);
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          // Hold until the output register is free
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {7'b0, side_q, hit_y_q, hit_x_q, vel_y_q, vel_x_q,
                          pos_y_q, pos_x_q};
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

>>> hw/rtl/bes_checker.sv
// Port-level assertions for the ball Euler step block, bound to the top level.
module bes_checker import bes_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [103:0] s_axis_tdata,
  input logic [0:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [95:0]  m_axis_tdata
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Drop ready while a request is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while busy");

  // A load with a free output passes the final state into the result register, verbatim, no hits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] && !m_axis_tvalid
    |=> ##1 (m_axis_tvalid
             && (m_axis_tdata[17:0] == $past(s_axis_tdata[33:16], 2))
             && (m_axis_tdata[35:18] == $past(s_axis_tdata[51:34], 2))
             && (m_axis_tdata[58:36] == $past(s_axis_tdata[74:52], 2))
             && (m_axis_tdata[81:59] == $past(s_axis_tdata[97:75], 2))
             && (m_axis_tdata[88:82] == 7'd0)))
    else $error("load result mismatch");

endmodule

bind ball_euler_step_with_bounce bes_checker u_bes_checker (.*);

>>> test/tb_ball_euler_step_with_bounce.sv
// Self-checking testbench for the ball Euler step block: stream driver, predictor and monitor.
`timescale 1ns / 100ps

module tb_ball_euler_step_with_bounce;
  import bes_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 30;    // covers one step request and then some
  localparam int unsigned STALL_LIMIT   = 2000;  // cycles without any handshake
  localparam longint FIELD_W_FX = longint'(FIELD_WIDTH_DEF) * 256;
  localparam longint FIELD_H_FX = longint'(FIELD_HEIGHT_DEF) * 256;

  typedef enum logic {OP_STEP = 1'b0, OP_LOAD = 1'b1} ball_op_e;

  typedef struct packed {
    ball_op_e           op;
    logic [15:0]        dt;
    logic [17:0]        pos_x;
    logic [17:0]        pos_y;
    logic signed [22:0] vel_x;
    logic signed [22:0] vel_y;
  } ball_cmd_t;

  typedef struct packed {
    logic [17:0]        pos_x;
    logic [17:0]        pos_y;
    logic signed [22:0] vel_x;
    logic signed [22:0] vel_y;
    logic [1:0]         hit_x;
    logic [1:0]         hit_y;
    logic [2:0]         side;
  } ball_state_t;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = REG_GRAVITY;
  logic [21:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // step_dt, load_pos_x, load_pos_y, load_vel_x, load_vel_y, zero pad
  logic [103:0] s_axis_tdata = '0;
  // opcode
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // pos_x, pos_y, vel_x, vel_y, wall_hit_x, wall_hit_y, platform_side, zero pad
  logic [95:0]  m_axis_tdata;

  ball_euler_step_with_bounce u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Predicted ball state and register copies
  longint ball_px = 0, ball_py = 0, ball_vx = 0, ball_vy = 0;
  longint cfg_gravity   = GRAVITY_RST;
  longint cfg_drag      = DRAG_RST;
  longint cfg_elastic   = ELASTICITY_RST;
  longint cfg_radius    = RADIUS_RST;
  longint cfg_plat_left = PLAT_LEFT_RST;
  longint cfg_plat_top  = PLAT_TOP_RST;
  longint cfg_plat_w    = PLAT_W_RST;
  longint cfg_plat_h    = PLAT_H_RST;

  ball_cmd_t   pending_cmds[$];
  ball_state_t expected_states[$];
  ball_cmd_t   driven_cmd;
  int unsigned cmds_issued = 0;
  int unsigned states_checked = 0;
  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned sink_hold = 0;
  int unsigned stall_cycles = 0;
  bit          gap_free_run = 1'b0;
  bit          steady_phase = 1'b0;

  // Shift right with rounding to nearest, ties away from zero
  function automatic longint round_half_away(input longint x, input int unsigned k);
    longint m;
    m = (x < 0) ? -x : x;
    m = (m + (longint'(1) << (k - 1))) >> k;
    return (x < 0) ? -m : m;
  endfunction

  function automatic longint limit_vel(input longint v);
    if (v > VEL_MAX) return VEL_MAX;
    if (v < VEL_MIN) return VEL_MIN;
    return v;
  endfunction

  function automatic longint limit_pos(input longint p);
    if (p < 0) return 0;
    if (p > POS_MAX) return POS_MAX;
    return p;
  endfunction

  // Reverse a velocity and scale it by the elasticity, capped at one
  function automatic longint bounce(input longint v);
    longint e;
    e = (cfg_elastic > longint'(ELAS_ONE)) ? longint'(ELAS_ONE) : cfg_elastic;
    return limit_vel(-round_half_away(v * e, 16));
  endfunction

  // Advance the predicted ball by one request and return the result it reports
  function automatic ball_state_t predict_ball(input ball_cmd_t c);
    ball_state_t s;
    longint dt, ax, ay, vx, vy, px, py, r, pl, pt, pr, pb;
    logic in_x, in_y;
    s = '0;
    if (c.op == OP_LOAD) begin
      ball_px = c.pos_x;
      ball_py = c.pos_y;
      ball_vx = longint'($signed(c.vel_x));
      ball_vy = longint'($signed(c.vel_y));
    end else begin
      dt = c.dt;
      r  = cfg_radius;
      // semi-implicit Euler: velocity first, then position with the new velocity
      ax = -cfg_drag * ball_vx;
      ay = cfg_gravity * 4096 - cfg_drag * ball_vy;
      vx = limit_vel(ball_vx + round_half_away(ax * dt, 28));
      vy = limit_vel(ball_vy + round_half_away(ay * dt, 28));
      px = ball_px + round_half_away(vx * dt, 16);
      py = ball_py + round_half_away(vy * dt, 16);
      pl = cfg_plat_left;
      pt = cfg_plat_top;
      pr = pl + cfg_plat_w;
      pb = pt + cfg_plat_h;
      // field walls, low side tested first
      if (px - r < 0) begin
        px = r; vx = bounce(vx); s.hit_x = HIT_LOW;
      end else if (px + r > FIELD_W_FX) begin
        px = FIELD_W_FX - r; vx = bounce(vx); s.hit_x = HIT_HIGH;
      end
      if (py - r < 0) begin
        py = r; vy = bounce(vy); s.hit_y = HIT_LOW;
      end else if (py + r > FIELD_H_FX) begin
        py = FIELD_H_FX - r; vy = bounce(vy); s.hit_y = HIT_HIGH;
      end
      px = limit_pos(px);
      py = limit_pos(py);
      // platform: first matching side only
      in_x = (px + r > pl) && (px - r < pr);
      in_y = (py + r > pt) && (py - r < pb);
      if (py + r > pt && py < pt && in_x && vy > 0) begin
        py = pt - r; vy = bounce(vy); s.side = SIDE_TOP;
      end else if (py - r < pb && py > pb && in_x && vy < 0) begin
        py = pb + r; vy = bounce(vy); s.side = SIDE_BOTTOM;
      end else if (px + r > pl && px < pl && in_y && vx > 0) begin
        px = pl - r; vx = bounce(vx); s.side = SIDE_LEFT;
      end else if (px - r < pr && px > pr && in_y && vx < 0) begin
        px = pr + r; vx = bounce(vx); s.side = SIDE_RIGHT;
      end
      ball_px = limit_pos(px);
      ball_py = limit_pos(py);
      ball_vx = vx;
      ball_vy = vy;
    end
    s.pos_x = ball_px[17:0];
    s.pos_y = ball_py[17:0];
    s.vel_x = ball_vx[22:0];
    s.vel_y = ball_vy[22:0];
    return s;
  endfunction

  task automatic push_step(input logic [15:0] dt);
    ball_cmd_t c;
    // load fields carry junk that a step must ignore
    c.op    = OP_STEP;
    c.dt    = dt;
    c.pos_x = 18'($urandom);
    c.pos_y = 18'($urandom);
    c.vel_x = 23'($urandom);
    c.vel_y = 23'($urandom);
    pending_cmds = {pending_cmds, c};
    cmds_issued++;
  endtask

  task automatic push_load(input logic [17:0] x, input logic [17:0] y,
                           input logic [22:0] vx, input logic [22:0] vy);
    ball_cmd_t c;
    c.op    = OP_LOAD;
    c.dt    = 16'($urandom);
    c.pos_x = x;
    c.pos_y = y;
    c.vel_x = vx;
    c.vel_y = vy;
    pending_cmds = {pending_cmds, c};
    cmds_issued++;
  endtask

  // Wait for every expected result, then let the block settle
  task automatic wait_idle();
    wait (states_checked == cmds_issued);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [21:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_GRAVITY:    cfg_gravity   = val;
      REG_DRAG:       cfg_drag      = val[15:0];
      REG_ELASTICITY: cfg_elastic   = val[16:0];
      REG_RADIUS:     cfg_radius    = val[15:0];
      REG_PLAT_LEFT:  cfg_plat_left = val[17:0];
      REG_PLAT_TOP:   cfg_plat_top  = val[17:0];
      REG_PLAT_W:     cfg_plat_w    = val[17:0];
      REG_PLAT_H:     cfg_plat_h    = val[17:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [21:0] grav, input logic [21:0] drag,
                              input logic [21:0] elas, input logic [21:0] radius,
                              input logic [21:0] left, input logic [21:0] top,
                              input logic [21:0] width, input logic [21:0] height);
    write_reg(REG_GRAVITY, grav);
    write_reg(REG_DRAG, drag);
    write_reg(REG_ELASTICITY, elas);
    write_reg(REG_RADIUS, radius);
    write_reg(REG_PLAT_LEFT, left);
    write_reg(REG_PLAT_TOP, top);
    write_reg(REG_PLAT_W, width);
    write_reg(REG_PLAT_H, height);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Queue flights: a load followed by a run of steps, some loads placed near the platform
  task automatic run_flights(input int unsigned n_cmds);
    int unsigned pushed, n_steps, mode, pick;
    longint r, x, y;
    logic [22:0] vx, vy;
    logic [15:0] dt;
    pushed = 0;
    while (pushed < n_cmds) begin
      r    = cfg_radius;
      mode = $urandom_range(0, 99);
      vx   = 23'(int'($urandom_range(0, 409600)) - 204800);
      vy   = 23'(int'($urandom_range(0, 409600)) - 204800);
      if (mode < 40) begin
        x = longint'($urandom_range(0, int'(FIELD_W_FX)));
        y = longint'($urandom_range(0, int'(FIELD_H_FX)));
      end else if (mode < 75) begin
        x = limit_pos(cfg_plat_left - 2 * r + $urandom_range(0, int'(cfg_plat_w + 4 * r)));
        y = limit_pos(cfg_plat_top - 2 * r + $urandom_range(0, int'(cfg_plat_h + 4 * r)));
      end else begin
        x  = longint'($urandom_range(0, 262143));
        y  = longint'($urandom_range(0, 262143));
        vx = 23'($urandom);
        vy = 23'($urandom);
      end
      push_load(x[17:0], y[17:0], vx, vy);
      n_steps = $urandom_range(3, 20);
      for (int unsigned i = 0; i < n_steps; i++) begin
        pick = $urandom_range(0, 19);
        if (pick < 16) dt = 16'($urandom_range(100, 4000));
        else if (pick < 19) dt = 16'($urandom);
        else dt = '0;
        push_step(dt);
      end
      pushed += 1 + n_steps;
    end
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_state(input logic [95:0] beat);
    ball_state_t want;
    if (expected_states.size() == 0) begin
      $error("result with no request outstanding: %h", beat);
      mismatches++;
    end else begin
      want = expected_states.pop_front();
      check_field("pos_x", want.pos_x, beat[17:0]);
      check_field("pos_y", want.pos_y, beat[35:18]);
      check_field("vel_x", want.vel_x, $signed(beat[58:36]));
      check_field("vel_y", want.vel_y, $signed(beat[81:59]));
      check_field("wall_hit_x", want.hit_x, beat[83:82]);
      check_field("wall_hit_y", want.hit_y, beat[85:84]);
      check_field("platform_side", want.side, beat[88:86]);
      states_checked++;
    end
  endtask

  // Request driver: predict on acceptance, present the next queued request after any gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_states = {expected_states, predict_ball(driven_cmd)};
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          if (s_axis_tready || gap_free_run) send_gap = send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          driven_cmd = pending_cmds.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'd0, driven_cmd.vel_y, driven_cmd.vel_x, driven_cmd.pos_y,
                            driven_cmd.pos_x, driven_cmd.dt};
          s_axis_tuser  <= driven_cmd.op;
          if (!steady_phase && $urandom_range(0, 4) == 0) begin
            send_gap     = $urandom_range(1, 10);
            gap_free_run = 1'($urandom_range(0, 1));
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each accepted result, stall in random bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_state(m_axis_tdata);
      if (sink_hold != 0) begin
        sink_hold = sink_hold - 1;
        m_axis_tready <= 1'b0;
      end else if (!steady_phase && $urandom_range(0, 7) == 0) begin
        sink_hold = $urandom_range(0, 9);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no handshake happens for too long
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : main_seq
    logic [21:0] elas_pick;
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero state, field extremes, each platform side, top wall
    push_step(16'd0);
    push_step(16'hffff);
    push_load(18'd0, 18'd0, 23'd0, 23'd0);
    push_step(16'd1);
    push_load(18'h3ffff, 18'h3ffff, 23'h3fffff, 23'h3fffff);
    push_step(16'hffff);
    push_load(18'd0, 18'd0, 23'h400000, 23'h400000);
    push_step(16'hffff);
    push_load(18'd128000, 18'd151040, 23'd0, 23'd25600);
    push_step(16'd655);
    push_load(18'd128000, 18'd160000, 23'd0, -23'sd25600);
    push_step(16'd655);
    push_load(18'd48640, 18'd156160, 23'd25600, 23'd0);
    push_step(16'd655);
    push_load(18'd207360, 18'd156160, -23'sd25600, 23'd0);
    push_step(16'd655);
    push_load(18'd128000, 18'd6000, 23'd0, -23'sd204800);
    push_step(16'd4000);
    push_load(18'h2aaaa, 18'h15555, 23'h2aaaaa, 23'h555555);
    push_step(16'h5555);
    wait_idle();

    // Upper extremes, elasticity above one, platform covering the field
    apply_config(22'h3fffff, 22'hffff, 22'h1ffff, 22'hffff, 22'd0, 22'd0,
                 22'h3ffff, 22'h3ffff);
    run_flights(115);
    wait_idle();

    // Lower extremes, platform pushed past the field
    apply_config(22'd0, 22'd0, 22'd0, 22'd0, 22'h3ffff, 22'h3ffff, 22'd0, 22'd0);
    run_flights(115);
    wait_idle();

    // Random settings; hold the sender halfway until all results are back
    repeat (2) begin
      elas_pick = ($urandom_range(0, 3) == 0) ? 22'($urandom_range(65536, 131071))
                                                : 22'($urandom_range(0, 65536));
      apply_config(22'($urandom_range(0, 600000)), 22'($urandom_range(0, 8192)), elas_pick,
                   22'($urandom_range(0, 12800)), 22'($urandom_range(0, 200000)),
                   22'($urandom_range(0, 170000)), 22'($urandom_range(0, 90000)),
                   22'($urandom_range(0, 20000)));
      run_flights(60);
      wait_idle();
      run_flights(55);
      wait_idle();
    end

    // Back to reset values, no idling on either side
    steady_phase = 1'b1;
    apply_config(GRAVITY_RST, 22'(DRAG_RST), 22'(ELASTICITY_RST), 22'(RADIUS_RST),
                 22'(PLAT_LEFT_RST), 22'(PLAT_TOP_RST), 22'(PLAT_W_RST), 22'(PLAT_H_RST));
    run_flights(115);
    wait_idle();

    if (expected_states.size() != 0) begin
      $error("%0d expected results never arrived", expected_states.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
